/* hw/rtl/x2a_pkg.sv */
// Shared types and constants for the x86 to A64 instruction translator.
`timescale 1ns / 1ps

package x2a_pkg;

    // x86 operation codes
    localparam logic [2:0] CMD_NOP  = 3'd0;
    localparam logic [2:0] CMD_MOV  = 3'd1;
    localparam logic [2:0] CMD_ADD  = 3'd2;
    localparam logic [2:0] CMD_SUB  = 3'd3;
    localparam logic [2:0] CMD_IMUL = 3'd4;
    localparam logic [2:0] CMD_CMP  = 3'd5;
    localparam logic [2:0] CMD_RET  = 3'd6;

    // source operand forms
    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_IMM = 2'd1;

    // A64 base encodings
    localparam logic [31:0] A64_NOP     = 32'hD503201F;
    localparam logic [31:0] A64_RET     = 32'hD65F03C0;
    localparam logic [31:0] A64_ORR_REG = 32'hAA0003E0;
    localparam logic [31:0] A64_MOVZ    = 32'hD2800000;
    localparam logic [31:0] A64_MOVK_16 = 32'hF2A00000;
    localparam logic [31:0] A64_MOVK_32 = 32'hF2C00000;
    localparam logic [31:0] A64_MOVK_48 = 32'hF2E00000;
    localparam logic [31:0] A64_ADD_REG = 32'h8B000000;
    localparam logic [31:0] A64_ADD_IMM = 32'h91000000;
    localparam logic [31:0] A64_SUB_REG = 32'hCB000000;
    localparam logic [31:0] A64_SUB_IMM = 32'hD1000000;
    localparam logic [31:0] A64_MUL     = 32'h9B007C00;
    localparam logic [31:0] A64_CMP_REG = 32'hEB00001F;
    localparam logic [31:0] A64_CMP_IMM = 32'hF100001F;

    localparam int MAX_WORDS = 4;
    localparam int IDX_W     = $clog2(MAX_WORDS);

    typedef struct packed {
        logic [2:0]  command;
        logic        active;
        logic        dst_is_register;
        logic [1:0]  src_kind;
        logic [3:0]  dst_reg;
        logic [3:0]  src_reg;
        logic [63:0] immediate;
    } insn_t;

    typedef struct packed {
        logic                              valid;
        logic [IDX_W-1:0]                  last_idx;
        logic [MAX_WORDS-1:0][31:0]        words;
    } enc_result_t;

endpackage

/* hw/rtl/x2a_encode.sv */
// Combinational encoder: one decoded x86 instruction to up to four A64 words.
`timescale 1ns / 1ps

module x2a_encode
(
    input  x2a_pkg::insn_t      insn,
    output x2a_pkg::enc_result_t result
);

    logic [31:0] rd;
    logic [31:0] rn;
    logic [31:0] rm;
    logic [31:0] imm12;
    logic        reg_form;
    logic        imm_form;

    assign rd       = 32'(insn.dst_reg);
    assign rn       = 32'(insn.dst_reg) << 5;
    assign rm       = 32'(insn.src_reg) << 16;
    assign imm12    = 32'(insn.immediate[11:0]) << 10;
    assign reg_form = insn.dst_is_register && (insn.src_kind == x2a_pkg::KIND_REG);
    assign imm_form = insn.dst_is_register && (insn.src_kind == x2a_pkg::KIND_IMM);

    always_comb
    begin
        result          = '0;
        result.last_idx = '0;
        if (insn.active)
        begin
            case (insn.command)
                x2a_pkg::CMD_NOP:
                begin
                    result.valid    = 1'b1;
                    result.words[0] = x2a_pkg::A64_NOP;
                end
                x2a_pkg::CMD_RET:
                begin
                    result.valid    = 1'b1;
                    result.words[0] = x2a_pkg::A64_RET;
                end
                x2a_pkg::CMD_MOV:
                begin
                    if (reg_form)
                    begin
                        // mov to itself emits nothing
                        result.valid    = (insn.dst_reg != insn.src_reg);
                        result.words[0] = x2a_pkg::A64_ORR_REG | rm | rd;
                    end
                    else if (imm_form)
                    begin
                        result.valid    = 1'b1;
                        result.last_idx = x2a_pkg::IDX_W'(x2a_pkg::MAX_WORDS - 1);
                        result.words[0] = x2a_pkg::A64_MOVZ
                                        | (32'(insn.immediate[15:0]) << 5) | rd;
                        result.words[1] = x2a_pkg::A64_MOVK_16
                                        | (32'(insn.immediate[31:16]) << 5) | rd;
                        result.words[2] = x2a_pkg::A64_MOVK_32
                                        | (32'(insn.immediate[47:32]) << 5) | rd;
                        result.words[3] = x2a_pkg::A64_MOVK_48
                                        | (32'(insn.immediate[63:48]) << 5) | rd;
                    end
                end
                x2a_pkg::CMD_ADD:
                begin
                    result.valid    = reg_form || imm_form;
                    result.words[0] = reg_form ? (x2a_pkg::A64_ADD_REG | rm | rn | rd)
                                               : (x2a_pkg::A64_ADD_IMM | imm12 | rn | rd);
                end
                x2a_pkg::CMD_SUB:
                begin
                    result.valid    = reg_form || imm_form;
                    result.words[0] = reg_form ? (x2a_pkg::A64_SUB_REG | rm | rn | rd)
                                               : (x2a_pkg::A64_SUB_IMM | imm12 | rn | rd);
                end
                x2a_pkg::CMD_IMUL:
                begin
                    result.valid    = reg_form;
                    result.words[0] = x2a_pkg::A64_MUL | rm | rn | rd;
                end
                x2a_pkg::CMD_CMP:
                begin
                    // destination is XZR, already in the base word
                    result.valid    = reg_form || imm_form;
                    result.words[0] = reg_form ? (x2a_pkg::A64_CMP_REG | rm | rn)
                                               : (x2a_pkg::A64_CMP_IMM | imm12 | rn);
                end
                default:
                begin
                    result.valid    = 1'b1;
                    result.words[0] = x2a_pkg::A64_NOP;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/x2a_out_buf.sv */
// Result register: holds the words of one item and sends them one per beat.
`timescale 1ns / 1ps

module x2a_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  x2a_pkg::enc_result_t result,
    output logic                 ready,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // instruction_word[31:0]
    output logic                 m_axis_tlast    // last
);

    logic                                         valid_reg;
    logic                                         valid_next;
    logic [x2a_pkg::IDX_W-1:0]                    idx_reg;
    logic [x2a_pkg::IDX_W-1:0]                    idx_next;
    logic [x2a_pkg::IDX_W-1:0]                    last_idx_reg;
    logic [x2a_pkg::MAX_WORDS-1:0][31:0]          words_reg;
    logic                                         final_beat;

    assign final_beat    = valid_reg && m_axis_tready && (idx_reg == last_idx_reg);
    assign ready         = !valid_reg || final_beat;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = words_reg[idx_reg];
    assign m_axis_tlast  = (idx_reg == last_idx_reg);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load && ready)
        begin
            // items that emit nothing leave the buffer empty
            valid_next = result.valid;
            idx_next   = '0;
        end
        else if (final_beat)
        begin
            valid_next = 1'b0;
        end
        else if (valid_reg && m_axis_tready)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            words_reg    <= result.words;
            last_idx_reg <= result.last_idx;
        end
    end

endmodule

/* hw/rtl/x86_to_a64_instruction_translator.sv */
// Top level: input register, encoder and output buffer of the translator.
`timescale 1ns / 1ps

// Translates one decoded x86 instruction per item into A64 instruction words.
// An item is registered on entry, encoded combinationally and placed in the
// output buffer, which sends its words one per beat with tlast on the final
// word. Items that give one word (or none) flow at one item per cycle while
// m_axis_tready stays high; a mov of an immediate gives four words and holds
// the output buffer for four beats. The input register feeds the output buffer
// register; inactive items and unhandled operand forms produce no output item.

module x86_to_a64_instruction_translator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // dst_reg[3:0], src_reg[7:4], immediate[71:8]
    input  logic [6:0]  s_axis_tuser,  // command[2:0], active[3], dst_is_register[4],
                                       // src_kind[6:5]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // instruction_word[31:0]
    output logic        m_axis_tlast   // last
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    x2a_pkg::insn_t       in_insn_reg;
    x2a_pkg::insn_t       in_insn;
    x2a_pkg::enc_result_t enc_result;
    logic                 buf_ready;

    always_comb
    begin
        in_insn.command         = s_axis_tuser[2:0];
        in_insn.active          = s_axis_tuser[3];
        in_insn.dst_is_register = s_axis_tuser[4];
        in_insn.src_kind        = s_axis_tuser[6:5];
        in_insn.dst_reg         = s_axis_tdata[3:0];
        in_insn.src_reg         = s_axis_tdata[7:4];
        in_insn.immediate       = s_axis_tdata[71:8];
    end

    // a held item leaves whenever the output buffer can take it
    assign s_axis_tready = !in_valid_reg || buf_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_insn_reg <= in_insn;
        end
    end

    x2a_encode u_encode
    (
        .insn   (in_insn_reg),
        .result (enc_result)
    );

    x2a_out_buf u_out_buf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (in_valid_reg),
        .result        (enc_result),
        .ready         (buf_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
